// File: sv/ppmd_pkg.sv
// ppmd_pkg: shared types and constants for the ppm pulse train decoder
// no dependencies; used by ppmd_div and ppm_pulse_train_decoder
package ppmd_pkg;

  // timer and value widths
  localparam int CountW  = 16;
  localparam int SlotW   = 3;
  localparam int ChanW   = 3;
  localparam int ValueW  = 16;
  localparam int QuoW    = 15;
  localparam int MapW    = 24;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;

  // channel count default
  localparam int NumChannelsDef = 6;

  // register reset values
  localparam logic [CountW-1:0] SyncThreshRst = 16'd8500;
  localparam logic [CountW-1:0] MinWidthRst   = 16'd700;
  localparam logic [CountW-1:0] WidthSpanRst  = 16'd1000;
  localparam logic [MapW-1:0]   ChanMapRst    = 24'd16434376;

  // full scale in q1.15
  localparam logic [ValueW-1:0] FullScale = 16'h8000;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_THRESHOLD = 2'd0,
    CFG_MIN_WIDTH      = 2'd1,
    CFG_WIDTH_SPAN     = 2'd2,
    CFG_CHANNEL_MAP    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              level;
    logic [CountW-1:0] edge_count;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic [ValueW-1:0] value;
  } out_item_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: sv/ppm_pulse_train_decoder.sv
// ppm_pulse_train_decoder: one line edge per item; rising edges store the timer count,
// falling edges give one q1.15 result, except a sync edge (wider than the sync threshold) that resets
// the slot; a result is clamped or comes from the serial divide (15 quotient bits, one per cycle), and
// waits in EMIT while the output stalls. one item in flight: input is ready only in the idle state.
// reset (rst_n, synchronous) loads register defaults, clears slot and count.
module ppm_pulse_train_decoder #(
  parameter int NUM_CHANNELS = ppmd_pkg::NumChannelsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ppmd_pkg::in_item_t            in_item,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output ppmd_pkg::out_item_t           out_item,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppmd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ppmd_pkg::CfgW-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [ppmd_pkg::SlotW-1:0] LastSlot = ppmd_pkg::SlotW'(NUM_CHANNELS - 1);

  state_t                              state_r, state_nxt;
  logic [ppmd_pkg::CountW-1:0]         sync_thresh_r, min_width_r, width_span_r;
  logic [ppmd_pkg::MapW-1:0]           chan_map_r;
  logic [ppmd_pkg::CountW-1:0]         start_count_r, start_count_nxt;
  logic [ppmd_pkg::SlotW-1:0]          slot_r, slot_nxt;
  logic [ppmd_pkg::CountW-1:0]         width_r, width_nxt;
  logic [ppmd_pkg::ChanW-1:0]          chan_r, chan_nxt;
  logic [ppmd_pkg::ValueW-1:0]         value_r, value_nxt;
  logic                                out_valid_r, out_valid_nxt;
  ppmd_pkg::out_item_t                 out_item_r, out_item_nxt;
  logic [ppmd_pkg::CountW-1:0]         cnt_diff;
  logic [ppmd_pkg::CountW-1:0]         width_d;
  logic                                in_acc;
  logic                                out_free;
  ppmd_pkg::div_ctl_t                  div_ctl;
  ppmd_pkg::div_sts_t                  div_sts;
  logic [ppmd_pkg::QuoW-1:0]           div_quo;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_thresh_r <= ppmd_pkg::SyncThreshRst;
      min_width_r   <= ppmd_pkg::MinWidthRst;
      width_span_r  <= ppmd_pkg::WidthSpanRst;
      chan_map_r    <= ppmd_pkg::ChanMapRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppmd_pkg::cfg_idx_t'(cfg_index))
        ppmd_pkg::CFG_SYNC_THRESHOLD: sync_thresh_r <= cfg_data[ppmd_pkg::CountW-1:0];
        ppmd_pkg::CFG_MIN_WIDTH:      min_width_r   <= cfg_data[ppmd_pkg::CountW-1:0];
        ppmd_pkg::CFG_WIDTH_SPAN:     width_span_r  <= cfg_data[ppmd_pkg::CountW-1:0];
        ppmd_pkg::CFG_CHANNEL_MAP:    chan_map_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pulse width with timer wrap: a non-positive difference loses one tick
  assign cnt_diff = in_item.edge_count - start_count_r;
  assign width_d  = width_r - min_width_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    start_count_nxt = start_count_r;
    slot_nxt        = slot_r;
    width_nxt       = width_r;
    chan_nxt        = chan_r;
    value_nxt       = value_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_item_nxt    = out_item_r;
    div_ctl.start   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.level) begin
            start_count_nxt = in_item.edge_count;
          end else begin
            width_nxt = (in_item.edge_count > start_count_r) ? cnt_diff : cnt_diff - 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (width_r > sync_thresh_r) begin
          slot_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          chan_nxt = chan_map_r[slot_r*ppmd_pkg::ChanW +: ppmd_pkg::ChanW];
          slot_nxt = (slot_r >= LastSlot) ? '0 : slot_r + 1'b1;
          priority if (width_r <= min_width_r) begin
            value_nxt = '0;
            state_nxt = ST_EMIT;
          end else if (width_span_r == '0 || width_d >= width_span_r) begin
            value_nxt = ppmd_pkg::FullScale;
            state_nxt = ST_EMIT;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          value_nxt = {1'b0, div_quo};
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.channel = chan_r;
          out_item_nxt.value   = value_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      start_count_r <= '0;
      slot_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      start_count_r <= start_count_nxt;
      slot_r        <= slot_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    width_r    <= width_nxt;
    chan_r     <= chan_nxt;
    value_r    <= value_nxt;
    out_item_r <= out_item_nxt;
  end

  // serial divider for the in-range case
  ppmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (width_d),
    .divisor  (width_span_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // slot index never reaches the channel count
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LastSlot)
    else $error("slot index out of range");

  // divider finishes only while waiting on it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider result with no division pending");

  // results never exceed full scale
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.value <= ppmd_pkg::FullScale)
    else $error("result value above full scale");

  // a rising edge item finishes in its own cycle
  a_rise_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.level) |=> state_r == ST_IDLE)
    else $error("rising edge item not done in one cycle");

endmodule

// File: sv/ppmd_div.sv
// ppmd_div: bit-serial restoring divider, one quotient bit per cycle
// computes floor(d * 2^15 / span) for d < span; depends on ppmd_pkg
module ppmd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ppmd_pkg::div_ctl_t           ctl,
  input  logic [ppmd_pkg::CountW-1:0]  dividend,
  input  logic [ppmd_pkg::CountW-1:0]  divisor,
  output ppmd_pkg::div_sts_t           sts,
  output logic [ppmd_pkg::QuoW-1:0]    quotient
);

  localparam int CntW = $clog2(ppmd_pkg::QuoW);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CntW-1:0]              cnt_r, cnt_nxt;
  logic [ppmd_pkg::CountW-1:0]  rem_r, rem_nxt;
  logic [ppmd_pkg::CountW-1:0]  div_r, div_nxt;
  logic [ppmd_pkg::QuoW-1:0]    quo_r, quo_nxt;
  logic [ppmd_pkg::CountW:0]    shifted;
  logic [ppmd_pkg::CountW:0]    diff;
  logic                         take;

  // one restoring step: double the remainder, subtract if it fits
  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, div_r};
    take    = (shifted >= {1'b0, div_r});
  end

  // step sequencing
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(ppmd_pkg::QuoW - 1);
      rem_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = take ? diff[ppmd_pkg::CountW-1:0] : shifted[ppmd_pkg::CountW-1:0];
      quo_nxt = {quo_r[ppmd_pkg::QuoW-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

  // done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  // done only follows the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

  // remainder stays below the divisor while running
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && $past(busy_r)) |-> rem_r < div_r)
    else $error("divider remainder out of range");

endmodule
